### rtl/core/fdrj_pkg.sv
package fdrj_pkg;

    typedef enum logic [1:0] {
        ACT_PUSH_FRAME = 2'd0,
        ACT_PUSH_DET   = 2'd1,
        ACT_DRAIN      = 2'd2,
        ACT_NONE       = 2'd3
    } action_t;

    localparam logic [0:0] CFG_REORDER_WINDOW = 1'b0;
    localparam logic [0:0] CFG_PENDING_LIMIT  = 1'b1;

    localparam logic [15:0] WINDOW_RESET = 16'd4;
    localparam logic [4:0]  LIMIT_RESET  = 5'd16;

    // Result of one full scan over a table.
    typedef struct packed {
        logic        any;       // at least one valid entry
        logic        hit;       // entry matching the probe id
        logic [31:0] lo_seq;
        logic [31:0] hi_seq;
    } scan_t;

endpackage

### rtl/core/fdrj_table.sv
// One tag table: seq/tag memory with valid bits, a scan read port and
// running min/max/match. Memory reads are registered.
module fdrj_table #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    // scan cursor
    input  logic [AW-1:0] rd_addr,
    input  logic          scan_first,   // first entry of a scan in rd stage
    input  logic          scan_acc,     // accumulate the registered read
    input  logic [31:0]   probe_id,
    output fdrj_pkg::scan_t scan,
    output logic [AW-1:0] hit_addr,
    output logic [AW-1:0] lo_addr,
    output logic [AW-1:0] free_addr,
    output logic          free_any,
    output logic [AW:0]   count,
    output logic [31:0]   hit_tag,
    // write / clear
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [31:0]   wr_seq,
    input  logic [31:0]   wr_tag,
    input  logic          clr_en,
    input  logic [AW-1:0] clr_addr
);

    logic [31:0]    seq_mem [DEPTH];
    logic [31:0]    tag_mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [31:0]    rd_seq_reg;
    logic [31:0]    rd_tag_reg;
    logic           rd_vld_reg;
    logic [AW-1:0]  rd_addr_reg;
    logic           first_reg;
    fdrj_pkg::scan_t scan_reg;
    logic [AW-1:0]  hit_addr_reg;
    logic [AW-1:0]  lo_addr_reg;
    logic [AW-1:0]  free_addr_reg;
    logic           free_any_reg;
    logic [AW:0]    count_reg;
    logic [31:0]    hit_tag_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            seq_mem[wr_addr] <= wr_seq;
            tag_mem[wr_addr] <= wr_tag;
        end
        rd_seq_reg <= seq_mem[rd_addr];
        rd_tag_reg <= tag_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            rd_vld_reg  <= 1'b0;
            rd_addr_reg <= '0;
            first_reg   <= 1'b0;
        end
        else
        begin
            if (wr_en)
                valid_reg[wr_addr] <= 1'b1;
            if (clr_en)
                valid_reg[clr_addr] <= 1'b0;
            rd_vld_reg  <= valid_reg[rd_addr];
            rd_addr_reg <= rd_addr;
            first_reg   <= scan_first;
        end
    end

    // running accumulators over the registered read
    always_ff @(posedge clk)
    begin
        if (scan_acc)
        begin
            if (first_reg)
            begin
                scan_reg.any    <= rd_vld_reg;
                scan_reg.hit    <= rd_vld_reg && rd_seq_reg == probe_id;
                scan_reg.lo_seq <= rd_seq_reg;
                scan_reg.hi_seq <= rd_seq_reg;
                hit_addr_reg    <= rd_addr_reg;
                hit_tag_reg     <= rd_tag_reg;
                lo_addr_reg     <= rd_addr_reg;
                free_addr_reg   <= rd_addr_reg;
                free_any_reg    <= !rd_vld_reg;
                count_reg       <= {{AW{1'b0}}, rd_vld_reg};
            end
            else
            begin
                if (rd_vld_reg)
                begin
                    count_reg <= count_reg + 1'b1;
                    if (!scan_reg.any || rd_seq_reg < scan_reg.lo_seq)
                    begin
                        scan_reg.lo_seq <= rd_seq_reg;
                        lo_addr_reg     <= rd_addr_reg;
                    end
                    if (!scan_reg.any || rd_seq_reg > scan_reg.hi_seq)
                        scan_reg.hi_seq <= rd_seq_reg;
                    scan_reg.any <= 1'b1;
                    if (!scan_reg.hit && rd_seq_reg == probe_id)
                    begin
                        scan_reg.hit <= 1'b1;
                        hit_addr_reg <= rd_addr_reg;
                        hit_tag_reg  <= rd_tag_reg;
                    end
                end
                else if (!free_any_reg)
                begin
                    free_any_reg  <= 1'b1;
                    free_addr_reg <= rd_addr_reg;
                end
            end
        end
    end

    assign scan      = scan_reg;
    assign hit_addr  = hit_addr_reg;
    assign lo_addr   = lo_addr_reg;
    assign free_addr = free_addr_reg;
    assign free_any  = free_any_reg;
    assign count     = count_reg;
    assign hit_tag   = hit_tag_reg;

endmodule

### rtl/core/frame_detection_reorder_join_top.sv
// Frame/detection reorder join. A request (start high while busy low) pushes
// a frame tag, pushes a detection tag, or drains. Both tables sit in small
// synchronous memories with a valid bit per entry; every decision is made
// after one full scan of both tables (one read per entry plus the memory
// read and accumulate stages). A push keeps busy high for one scan and
// writes at its end; the next request is taken once busy is low. A drain
// costs one scan per released frame, per forward skip and per evicted
// entry, one more scan when no expected id is known yet, a closing scan,
// and the done marker state; busy stays high throughout. Results appear at
// most one per scan on the result ports with valid high for exactly one
// cycle; the receiver cannot stall, so it must take every valid cycle. The
// last result of a drain is the done marker (released low, last high).
// Configuration writes are taken at any time but are meant for idle periods.
module frame_detection_reorder_join_top #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  action,
    input  logic [31:0] seq_id,
    input  logic [31:0] payload_tag,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    output logic        valid,
    output logic [31:0] out_seq_id,
    output logic [31:0] frame_tag_out,
    output logic [31:0] det_tag_out,
    output logic        has_detections,
    output logic        released,
    output logic        last
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);
    localparam logic [AW:0]   DEPTH_CNT = (AW+1)'(TABLE_DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WAIT,
        ST_DECIDE,
        ST_DONE
    } state_t;

    state_t        state_reg;
    logic [1:0]    act_reg;
    logic [31:0]   id_reg;
    logic [31:0]   tag_reg;
    logic [15:0]   window_reg;
    logic [4:0]    limit_reg;
    logic [31:0]   exp_reg;
    logic          known_reg;
    logic [AW-1:0] addr_reg;
    logic [AW:0]   nrel_reg;
    logic          trim_reg;

    logic          valid_reg;
    logic [31:0]   o_seq_reg, o_ft_reg, o_dt_reg;
    logic          o_hd_reg, o_rel_reg, o_last_reg;

    logic          scan_first, scan_acc;
    logic [31:0]   probe;
    fdrj_pkg::scan_t f_scan, d_scan;
    logic [AW-1:0] f_hit, f_lo, f_free, d_hit, d_lo, d_free;
    logic          f_free_any, d_free_any;
    logic [AW:0]   f_cnt, d_cnt;
    logic [31:0]   f_tag, d_tag;
    logic          f_we, d_we, f_clr, d_clr;
    logic [AW-1:0] f_wa, d_wa, f_ca, d_ca;

    assign scan_first = (state_reg == ST_SCAN) && addr_reg == '0;
    assign scan_acc   = (state_reg == ST_SCAN && addr_reg != '0) || state_reg == ST_WAIT;
    assign probe      = (act_reg == fdrj_pkg::ACT_DRAIN) ? exp_reg : id_reg;

    fdrj_table #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_frame (
        .clk, .rst_n, .rd_addr(addr_reg), .scan_first, .scan_acc,
        .probe_id(probe), .scan(f_scan), .hit_addr(f_hit), .lo_addr(f_lo),
        .free_addr(f_free), .free_any(f_free_any), .count(f_cnt), .hit_tag(f_tag),
        .wr_en(f_we), .wr_addr(f_wa), .wr_seq(id_reg), .wr_tag(tag_reg),
        .clr_en(f_clr), .clr_addr(f_ca)
    );

    fdrj_table #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_det (
        .clk, .rst_n, .rd_addr(addr_reg), .scan_first, .scan_acc,
        .probe_id(probe), .scan(d_scan), .hit_addr(d_hit), .lo_addr(d_lo),
        .free_addr(d_free), .free_any(d_free_any), .count(d_cnt), .hit_tag(d_tag),
        .wr_en(d_we), .wr_addr(d_wa), .wr_seq(id_reg), .wr_tag(tag_reg),
        .clr_en(d_clr), .clr_addr(d_ca)
    );

    // Decision logic, evaluated in ST_DECIDE after a full scan.
    logic [31:0] seen;
    logic [4:0]  lim_eff;
    logic [AW:0] lim_cmp;
    logic        lim_big;
    logic        f_over, d_over;
    logic        is_push, push_f;
    logic        push_wr;
    logic [AW-1:0] push_addr;
    logic        pair, gap_skip, lone;
    logic        loop_ok;

    always_comb
    begin
        lim_eff = (limit_reg == 5'd0) ? 5'd1 : limit_reg;
        lim_big = ({27'd0, lim_eff} >= 32'(TABLE_DEPTH));
        lim_cmp = lim_big ? DEPTH_CNT : (AW+1)'(lim_eff);
        f_over  = f_cnt > lim_cmp;
        d_over  = d_cnt > lim_cmp;

        is_push = act_reg == fdrj_pkg::ACT_PUSH_FRAME || act_reg == fdrj_pkg::ACT_PUSH_DET;
        push_f  = act_reg == fdrj_pkg::ACT_PUSH_FRAME;
        if (push_f)
        begin
            push_addr = f_scan.hit ? f_hit : (f_free_any ? f_free : f_lo);
            push_wr   = f_scan.hit || f_free_any || f_scan.lo_seq < id_reg;
        end
        else
        begin
            push_addr = d_scan.hit ? d_hit : (d_free_any ? d_free : d_lo);
            push_wr   = d_scan.hit || d_free_any || d_scan.lo_seq < id_reg;
        end

        seen = exp_reg;
        if (f_scan.any && f_scan.hi_seq > seen)
            seen = f_scan.hi_seq;
        if (d_scan.any && d_scan.hi_seq > seen)
            seen = d_scan.hi_seq;
        loop_ok  = known_reg && nrel_reg < DEPTH_CNT && !trim_reg;
        pair     = loop_ok && f_scan.hit && d_scan.hit;
        gap_skip = loop_ok && !f_scan.hit && f_scan.any && f_scan.lo_seq > exp_reg;
        lone     = loop_ok && f_scan.hit && !d_scan.hit && seen > exp_reg
                   && (seen - exp_reg) > {16'd0, window_reg};
    end

    logic decide;
    assign decide = state_reg == ST_DECIDE;

    always_comb
    begin
        f_we  = decide && is_push && push_f && push_wr;
        d_we  = decide && is_push && !push_f && push_wr;
        f_wa  = push_addr;
        d_wa  = push_addr;
        f_clr = 1'b0;
        d_clr = 1'b0;
        f_ca  = f_hit;
        d_ca  = d_hit;
        if (decide && !is_push)
        begin
            if (pair || lone)
                f_clr = 1'b1;
            if (pair)
                d_clr = 1'b1;
            // eviction only once the release walk is over
            if (!(pair || gap_skip || lone) && (known_reg || trim_reg))
            begin
                // eviction phase: frames first, then detections
                if (f_over)
                begin
                    f_clr = 1'b1;
                    f_ca  = f_lo;
                end
                else if (d_over)
                begin
                    d_clr = 1'b1;
                    d_ca  = d_lo;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            window_reg <= fdrj_pkg::WINDOW_RESET;
            limit_reg  <= fdrj_pkg::LIMIT_RESET;
            exp_reg    <= '0;
            known_reg  <= 1'b0;
            addr_reg   <= '0;
            nrel_reg   <= '0;
            trim_reg   <= 1'b0;
            act_reg    <= fdrj_pkg::ACT_NONE;
            valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == fdrj_pkg::CFG_REORDER_WINDOW)
                    window_reg <= cfg_data;
                else
                    limit_reg <= cfg_data[4:0];
            end
            case (state_reg)
                ST_IDLE:
                begin
                    valid_reg <= 1'b0;
                    if (start && (action == fdrj_pkg::ACT_PUSH_FRAME
                                  || action == fdrj_pkg::ACT_PUSH_DET
                                  || action == fdrj_pkg::ACT_DRAIN))
                    begin
                        act_reg   <= action;
                        id_reg    <= seq_id;
                        tag_reg   <= payload_tag;
                        nrel_reg  <= '0;
                        trim_reg  <= 1'b0;
                        addr_reg  <= '0;
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    valid_reg <= 1'b0;
                    if (addr_reg == LAST_ADDR)
                    begin
                        addr_reg  <= '0;
                        state_reg <= ST_WAIT;
                    end
                    else
                        addr_reg <= addr_reg + 1'b1;
                end
                ST_WAIT:
                begin
                    // last entry is accumulated this cycle
                    valid_reg <= 1'b0;
                    state_reg <= ST_DECIDE;
                end
                ST_DECIDE:
                begin
                    if (is_push)
                    begin
                        valid_reg <= 1'b0;
                        state_reg <= ST_IDLE;
                    end
                    else if (!known_reg && !trim_reg)
                    begin
                        valid_reg <= 1'b0;
                        state_reg <= ST_SCAN;
                        if (f_scan.any)
                        begin
                            known_reg <= 1'b1;
                            exp_reg   <= f_scan.lo_seq;
                        end
                        else
                            trim_reg <= 1'b1;
                    end
                    else if (pair || lone)
                    begin
                        valid_reg  <= 1'b1;
                        o_seq_reg  <= exp_reg;
                        o_ft_reg   <= f_tag;
                        o_dt_reg   <= pair ? d_tag : 32'd0;
                        o_hd_reg   <= pair;
                        o_rel_reg  <= 1'b1;
                        o_last_reg <= 1'b0;
                        exp_reg    <= exp_reg + 32'd1;
                        nrel_reg   <= nrel_reg + 1'b1;
                        state_reg  <= ST_SCAN;
                    end
                    else if (gap_skip)
                    begin
                        valid_reg <= 1'b0;
                        exp_reg   <= f_scan.lo_seq;
                        state_reg <= ST_SCAN;
                    end
                    else
                    begin
                        valid_reg <= 1'b0;
                        trim_reg  <= 1'b1;
                        if (!f_over && !d_over)
                            state_reg <= ST_DONE;
                        else
                            state_reg <= ST_SCAN;
                    end
                end
                ST_DONE:
                begin
                    valid_reg  <= 1'b1;
                    o_seq_reg  <= '0;
                    o_ft_reg   <= '0;
                    o_dt_reg   <= '0;
                    o_hd_reg   <= 1'b0;
                    o_rel_reg  <= 1'b0;
                    o_last_reg <= 1'b1;
                    state_reg  <= ST_IDLE;
                end
                default:
                begin
                    valid_reg <= 1'b0;
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy           = state_reg != ST_IDLE;
    assign valid          = valid_reg;
    assign out_seq_id     = o_seq_reg;
    assign frame_tag_out  = o_ft_reg;
    assign det_tag_out    = o_dt_reg;
    assign has_detections = o_hd_reg;
    assign released       = o_rel_reg;
    assign last           = o_last_reg;

`ifndef SYNTHESIS
    // a done marker always ends the drain and returns to idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        valid && last |-> !busy) else $error("done marker without idle");
    // released and last are exclusive
    a_rel_last: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> (released != last)) else $error("bad result kind");
    // matched detections only come with a released frame
    a_hd_rel: assert property (@(posedge clk) disable iff (!rst_n)
        valid && has_detections |-> released) else $error("detections w/o frame");
`endif

endmodule

### tb/frame_detection_reorder_join_top_test.sv
module frame_detection_reorder_join_top_test;

    localparam int DEPTH = 16;
    // a drain can need dozens of scans
    localparam int IDLE_LIMIT = 40000;
    localparam int SETTLE_CYCLES = 4 * (DEPTH + 3);

    typedef struct packed {
        logic [31:0] seq;
        logic [31:0] ftag;
        logic [31:0] dtag;
        logic        has_det;
        logic        rel;
        logic        lst;
    } release_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  action;
    logic [31:0] seq_id;
    logic [31:0] payload_tag;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_data;
    logic        valid;
    logic [31:0] out_seq_id;
    logic [31:0] frame_tag_out;
    logic [31:0] det_tag_out;
    logic        has_detections;
    logic        released;
    logic        last;

    frame_detection_reorder_join_top #(
        .TABLE_DEPTH(DEPTH)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .action        (action),
        .seq_id        (seq_id),
        .payload_tag   (payload_tag),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .valid         (valid),
        .out_seq_id    (out_seq_id),
        .frame_tag_out (frame_tag_out),
        .det_tag_out   (det_tag_out),
        .has_detections(has_detections),
        .released      (released),
        .last          (last)
    );

    // Predictor state: shadow copy of both tables, the expected id and registers.
    logic [15:0] win_q;
    logic [4:0]  lim_q;
    logic        fr_v  [DEPTH];
    logic [31:0] fr_id [DEPTH];
    logic [31:0] fr_tag[DEPTH];
    logic        dt_v  [DEPTH];
    logic [31:0] dt_id [DEPTH];
    logic [31:0] dt_tag[DEPTH];
    logic [31:0] next_seq;
    logic        next_known;

    release_t expected_releases[$];
    int       errors;
    int       requests_sent;
    int       results_seen;
    int       drains_sent;
    int       idle_cycles;
    bit       test_done;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // ---------------------------------------------------------------
    // Table helpers on the shadow copy. The fr_* / dt_* split keeps the
    // unpacked arrays out of ref arguments.
    // ---------------------------------------------------------------
    function automatic int find_slot(bit is_det, logic [31:0] id);
        for (int i = 0; i < DEPTH; i++)
        begin
            if (!is_det && fr_v[i] && fr_id[i] == id) return i;
            if (is_det && dt_v[i] && dt_id[i] == id) return i;
        end
        return -1;
    endfunction

    // want_low=1 picks the lowest id, else the highest
    function automatic int extreme_slot(bit is_det, bit want_low);
        int best;
        logic [31:0] s;
        logic [31:0] b;
        best = -1;
        b = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (is_det ? dt_v[i] : fr_v[i])
            begin
                s = is_det ? dt_id[i] : fr_id[i];
                if (best < 0 || (want_low ? (s < b) : (s > b)))
                begin
                    best = i;
                    b = s;
                end
            end
        end
        return best;
    endfunction

    task automatic table_store(bit is_det, logic [31:0] id, logic [31:0] tag);
        int k;
        k = find_slot(is_det, id);
        if (k < 0)
        begin
            for (int i = 0; i < DEPTH && k < 0; i++)
                if (!(is_det ? dt_v[i] : fr_v[i])) k = i;
        end
        if (k < 0)
        begin
            // full table keeps the highest ids
            k = extreme_slot(is_det, 1'b1);
            if (k < 0 || (is_det ? dt_id[k] : fr_id[k]) >= id) return;
        end
        if (is_det)
        begin
            dt_v[k] = 1'b1; dt_id[k] = id; dt_tag[k] = tag;
        end
        else
        begin
            fr_v[k] = 1'b1; fr_id[k] = id; fr_tag[k] = tag;
        end
    endtask

    task automatic table_trim(bit is_det, int keep);
        int cnt;
        int k;
        cnt = 0;
        for (int i = 0; i < DEPTH; i++)
            if (is_det ? dt_v[i] : fr_v[i]) cnt++;
        while (cnt > keep)
        begin
            k = extreme_slot(is_det, 1'b1);
            if (is_det) dt_v[k] = 1'b0; else fr_v[k] = 1'b0;
            cnt--;
        end
    endtask

    function automatic release_t make_release(logic [31:0] s, logic [31:0] f,
                                              logic [31:0] d, logic h,
                                              logic r, logic l);
        release_t e;
        e.seq = s; e.ftag = f; e.dtag = d; e.has_det = h; e.rel = r; e.lst = l;
        return e;
    endfunction

    // Drain: walk from the expected id, release pairs, skip gaps, release
    // unmatched frames once the newest id leads by more than the window.
    task automatic predict_drain();
        int n;
        int f;
        int d;
        int lo;
        int hf;
        int hd;
        logic [31:0] lf;
        logic [31:0] ld;
        logic [31:0] newest;
        int keep;
        n = 0;
        if (!next_known)
        begin
            lo = extreme_slot(1'b0, 1'b1);
            if (lo >= 0)
            begin
                next_seq = fr_id[lo];
                next_known = 1'b1;
            end
        end
        while (next_known && n < DEPTH)
        begin
            f = find_slot(1'b0, next_seq);
            d = find_slot(1'b1, next_seq);
            if (f >= 0 && d >= 0)
            begin
                expected_releases.push_back(make_release(next_seq, fr_tag[f],
                                                         dt_tag[d], 1'b1, 1'b1, 1'b0));
                n++;
                fr_v[f] = 1'b0;
                dt_v[d] = 1'b0;
                next_seq++;
                continue;
            end
            if (f < 0)
            begin
                lo = extreme_slot(1'b0, 1'b1);
                if (lo >= 0 && fr_id[lo] > next_seq)
                begin
                    next_seq = fr_id[lo];
                    continue;
                end
                break;
            end
            hf = extreme_slot(1'b0, 1'b0);
            hd = extreme_slot(1'b1, 1'b0);
            lf = hf >= 0 ? fr_id[hf] : next_seq;
            ld = hd >= 0 ? dt_id[hd] : next_seq;
            newest = lf > ld ? lf : ld;
            if (newest > next_seq && (newest - next_seq) > {16'd0, win_q})
            begin
                expected_releases.push_back(make_release(next_seq, fr_tag[f],
                                                         '0, 1'b0, 1'b1, 1'b0));
                n++;
                fr_v[f] = 1'b0;
                next_seq++;
                continue;
            end
            break;
        end
        keep = (lim_q == 0) ? 1 : int'(lim_q);
        table_trim(1'b0, keep);
        table_trim(1'b1, keep);
        expected_releases.push_back(make_release('0, '0, '0, 1'b0, 1'b0, 1'b1));
    endtask

    // ---------------------------------------------------------------
    // Sending side
    // ---------------------------------------------------------------
    int burst_left;

    // One request: present at the falling edge, hold until taken. Within a
    // burst start stays high into the next request; idling drops it.
    task automatic send_request(fdrj_pkg::action_t act, logic [31:0] id,
                                logic [31:0] tag);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        start       <= 1'b1;
        action      <= act;
        seq_id      <= id;
        payload_tag <= tag;
        @(posedge clk);
        while (busy) @(posedge clk);
        case (act)
            fdrj_pkg::ACT_PUSH_FRAME: table_store(1'b0, id, tag);
            fdrj_pkg::ACT_PUSH_DET:   table_store(1'b1, id, tag);
            fdrj_pkg::ACT_DRAIN:
            begin
                predict_drain();
                drains_sent++;
            end
            default: ;
        endcase
        requests_sent++;
        @(negedge clk);
    endtask

    // Wait until all results are in, plus time for a trailing push scan.
    task automatic wait_quiet();
        start <= 1'b0;
        while (expected_releases.size() != 0 || busy) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == fdrj_pkg::CFG_REORDER_WINDOW) win_q = data;
        else lim_q = data[4:0];
    endtask

    // ---------------------------------------------------------------
    // Result checking: the receiver never stalls, sample every rising edge.
    // ---------------------------------------------------------------
    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("ERROR %0t: %s got %h want %h", $time, what, got, want);
        errors++;
    endtask

    always @(posedge clk)
    begin
        release_t want;
        if (rst_n && valid)
        begin
            results_seen++;
            if (expected_releases.size() == 0)
                report_mismatch("unexpected result, seq", out_seq_id, '0);
            else
            begin
                want = expected_releases.pop_front();
                if (out_seq_id !== want.seq)
                    report_mismatch("out_seq_id", out_seq_id, want.seq);
                if (frame_tag_out !== want.ftag)
                    report_mismatch("frame_tag_out", frame_tag_out, want.ftag);
                if (det_tag_out !== want.dtag)
                    report_mismatch("det_tag_out", det_tag_out, want.dtag);
                if (has_detections !== want.has_det)
                    report_mismatch("has_detections", 32'(has_detections),
                                    32'(want.has_det));
                if (released !== want.rel)
                    report_mismatch("released", 32'(released), 32'(want.rel));
                if (last !== want.lst)
                    report_mismatch("last", 32'(last), 32'(want.lst));
            end
        end
    end

    // Watchdog: cycles with no request taken and no result seen.
    always @(posedge clk)
    begin
        if (!rst_n || test_done || valid || (start && !busy))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Watchdog: no progress for %0d cycles", IDLE_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    task automatic test_empty_drain();
        send_request(fdrj_pkg::ACT_DRAIN, 32'hDEAD_BEEF, 32'h1234_5678);
        send_request(fdrj_pkg::ACT_NONE, 32'h5, 32'h5);
        send_request(fdrj_pkg::ACT_DRAIN, '0, '0);
    endtask

    // Pairs, an overwrite, wrap near 2^32 and extreme tags.
    task automatic test_directed_pairs();
        send_request(fdrj_pkg::ACT_PUSH_FRAME, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
        send_request(fdrj_pkg::ACT_PUSH_DET,   32'hFFFF_FFFE, 32'h0000_0000);
        send_request(fdrj_pkg::ACT_PUSH_FRAME, 32'hFFFF_FFFF, 32'hAAAA_5555);
        send_request(fdrj_pkg::ACT_PUSH_DET,   32'hFFFF_FFFF, 32'h5555_AAAA);
        send_request(fdrj_pkg::ACT_PUSH_DET,   32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(fdrj_pkg::ACT_DRAIN, '0, '0);
        send_request(fdrj_pkg::ACT_PUSH_FRAME, 32'h0, 32'h1);
        send_request(fdrj_pkg::ACT_PUSH_DET,   32'h0, 32'h2);
        send_request(fdrj_pkg::ACT_DRAIN, '0, '0);
        wait_quiet();
    endtask

    // Frames with no detections pushed past the window, stale detections.
    task automatic test_window_release();
        write_reg(fdrj_pkg::CFG_REORDER_WINDOW, 16'd0);
        for (int i = 0; i < 4; i++)
            send_request(fdrj_pkg::ACT_PUSH_FRAME, 32'd100 + i, $urandom);
        send_request(fdrj_pkg::ACT_PUSH_DET, 32'd2, 32'h77);
        send_request(fdrj_pkg::ACT_PUSH_DET, 32'd102, $urandom);
        send_request(fdrj_pkg::ACT_DRAIN, '0, '0);
        wait_quiet();
        write_reg(fdrj_pkg::CFG_REORDER_WINDOW, 16'hFFFF);
    endtask

    // Overfill both tables, then trim with a limit of zero.
    task automatic test_full_and_trim();
        for (int i = 0; i < DEPTH + 3; i++)
            send_request(fdrj_pkg::ACT_PUSH_FRAME, 32'd500 + i, $urandom);
        send_request(fdrj_pkg::ACT_PUSH_FRAME, 32'd1, 32'h99);
        for (int i = 0; i < DEPTH + 2; i++)
            send_request(fdrj_pkg::ACT_PUSH_DET, 32'd900 - i, $urandom);
        wait_quiet();
        write_reg(fdrj_pkg::CFG_PENDING_LIMIT, 16'd0);
        send_request(fdrj_pkg::ACT_DRAIN, '0, '0);
        wait_quiet();
        write_reg(fdrj_pkg::CFG_PENDING_LIMIT, 16'd31);
    endtask

    // Random phases: mostly in-order streams around a moving base with some
    // reordering, dropped ids and noise pushes.
    task automatic test_random_streams(int count);
        logic [31:0] base;
        int r;
        int sent;
        sent = 0;
        base = next_known ? next_seq : $urandom;
        while (sent < count)
        begin
            r = $urandom_range(0, 99);
            if (r < 40)
                send_request(fdrj_pkg::ACT_PUSH_FRAME, base + $urandom_range(0, 6),
                             $urandom);
            else if (r < 75)
                send_request(fdrj_pkg::ACT_PUSH_DET, base + $urandom_range(0, 6),
                             $urandom);
            else if (r < 90)
            begin
                send_request(fdrj_pkg::ACT_DRAIN, $urandom, $urandom);
                base = next_known ? next_seq : base;
                if ($urandom_range(0, 3) == 0) base += $urandom_range(0, 4);
            end
            else if (r < 95)
                send_request(fdrj_pkg::ACT_NONE, $urandom, $urandom);
            else
                send_request(fdrj_pkg::action_t'($urandom_range(0, 1)), $urandom,
                             $urandom);
            sent++;
        end
        send_request(fdrj_pkg::ACT_DRAIN, '0, '0);
        wait_quiet();
    endtask

    initial
    begin
        start = 1'b0; action = fdrj_pkg::ACT_NONE; seq_id = '0; payload_tag = '0;
        cfg_we = 1'b0; cfg_index = fdrj_pkg::CFG_REORDER_WINDOW; cfg_data = '0;
        errors = 0; requests_sent = 0; results_seen = 0; drains_sent = 0;
        idle_cycles = 0; test_done = 0; burst_left = 0;
        win_q = fdrj_pkg::WINDOW_RESET; lim_q = fdrj_pkg::LIMIT_RESET;
        for (int i = 0; i < DEPTH; i++)
        begin
            fr_v[i] = 0; fr_id[i] = '0; fr_tag[i] = '0;
            dt_v[i] = 0; dt_id[i] = '0; dt_tag[i] = '0;
        end
        next_seq = '0; next_known = 1'b0;
        rst_n = 1'b0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        wait_quiet();

        test_empty_drain();
        test_directed_pairs();
        test_window_release();
        test_full_and_trim();
        write_reg(fdrj_pkg::CFG_REORDER_WINDOW, 16'd4);
        write_reg(fdrj_pkg::CFG_PENDING_LIMIT, 16'd16);
        test_random_streams(150);
        write_reg(fdrj_pkg::CFG_REORDER_WINDOW, 16'd1);
        write_reg(fdrj_pkg::CFG_PENDING_LIMIT, 16'd4);
        test_random_streams(150);
        write_reg(fdrj_pkg::CFG_REORDER_WINDOW, 16'($urandom_range(0, 3)));
        write_reg(fdrj_pkg::CFG_PENDING_LIMIT, 16'd1);
        test_random_streams(100);

        test_done = 1;
        $display("Covered %0d requests including %0d drains, %0d results checked",
                 requests_sent, drains_sent, results_seen);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
